// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the snapshot envelope checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once out of reset.
`define SEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/sec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sec_pkg
// Types, constants and helpers shared by the snapshot envelope checker.
// ----------------------------------------------------------------------------
package sec_pkg;

  // Header layout, in byte positions from frame start
  localparam logic [4:0] VER_POS   = 5'd8;
  localparam logic [4:0] LEN_POS   = 5'd12;
  localparam logic [4:0] HASH_POS  = 5'd20;
  localparam logic [4:0] HDR_BYTES = 5'd28;

  // "OFSTATE1", first byte in the lowest lane
  localparam logic [63:0] MAGIC = 64'h3145_5441_5453_464F;

  localparam logic [63:0] FNV_BASIS     = 64'hCBF2_9CE4_8422_2325;
  localparam logic [31:0] EXP_VER_RESET = 32'd4;

  typedef enum logic [2:0] {
    V_OK      = 3'd0,
    V_TRUNC   = 3'd1,
    V_MAGIC   = 3'd2,
    V_VERSION = 3'd3,
    V_LENGTH  = 3'd4,
    V_HASH    = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    K_MAGIC = 3'd0,
    K_VER   = 3'd1,
    K_LEN   = 3'd2,
    K_HASH  = 3'd3,
    K_BODY  = 3'd4
  } kind_t;

  // One classified beat, handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
    logic [2:0] lane;  // byte lane within the header field
    logic [4:0] cnt;   // header bytes seen, this beat included
  } item_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] lane);
    magic_byte = MAGIC[{lane, 3'b000} +: 8];
  endfunction

  // FNV-1a 64 step; prime is 2^40 + 2^8 + 0xB3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

// File: sv/sec_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sec_queue
// Small register FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sec_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sec_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output sec_pkg::item_t      pop_item,
  output logic                not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sec_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SEC_ASSERT(a_no_push_full, !(push && full), "push into full queue")
  `SEC_ASSERT(a_no_pop_empty, !(pop && !not_empty), "pop from empty queue")

endmodule
`default_nettype wire

// File: sv/sec_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sec_front
// Accept stream beats, track header position, classify each beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sec_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data,
  input  wire logic       in_last,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       q_full,
  output logic            push,
  output sec_pkg::item_t  push_item
);

  logic [4:0] pos_r, pos_nxt;
  logic [4:0] off;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.data = in_data;
    push_item.last = in_last;
    push_item.cnt  = pos_r;
    off            = pos_r;
    if (pos_r < sec_pkg::VER_POS) begin
      push_item.kind = sec_pkg::K_MAGIC;
    end else if (pos_r < sec_pkg::LEN_POS) begin
      push_item.kind = sec_pkg::K_VER;
      off            = pos_r - sec_pkg::VER_POS;
    end else if (pos_r < sec_pkg::HASH_POS) begin
      push_item.kind = sec_pkg::K_LEN;
      off            = pos_r - sec_pkg::LEN_POS;
    end else if (pos_r < sec_pkg::HDR_BYTES) begin
      push_item.kind = sec_pkg::K_HASH;
      off            = pos_r - sec_pkg::HASH_POS;
    end else begin
      push_item.kind = sec_pkg::K_BODY;
    end
    push_item.lane = off[2:0];
    // Header count after this beat; body beats leave it at the header size
    if (pos_r != sec_pkg::HDR_BYTES) begin
      push_item.cnt = pos_r + 5'd1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_last ? '0 : push_item.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  `SEC_ASSERT(a_pos_range, pos_r <= sec_pkg::HDR_BYTES, "header position past header size")

endmodule
`default_nettype wire

// File: sv/sec_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sec_back
// Capture header fields, hash and count the body, judge the frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sec_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [31:0]    cfg_wr_data,
  input  wire logic           q_not_empty,
  input  wire sec_pkg::item_t q_item,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_body,
  output logic                out_last,
  output logic [2:0]          out_verdict
);

  logic [31:0] exp_ver_r;
  logic        magic_r, magic_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] rhash_r, rhash_nxt;
  logic [63:0] cnt_r, cnt_nxt;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_body_r;
  logic              out_last_r;
  sec_pkg::verdict_t out_verdict_r, verdict;

  assign pop         = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_body    = out_body_r;
  assign out_last    = out_last_r;
  assign out_verdict = out_verdict_r;

  // Field and hash updates for the beat at the queue head
  always_comb begin
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    len_nxt   = len_r;
    hash_nxt  = hash_r;
    rhash_nxt = rhash_r;
    cnt_nxt   = cnt_r;
    case (q_item.kind)
      sec_pkg::K_MAGIC: begin
        if (q_item.data != sec_pkg::magic_byte(q_item.lane)) begin
          magic_nxt = 1'b0;
        end
      end
      sec_pkg::K_VER:  ver_nxt[{q_item.lane[1:0], 3'b000} +: 8] = q_item.data;
      sec_pkg::K_LEN:  len_nxt[{q_item.lane, 3'b000} +: 8]      = q_item.data;
      sec_pkg::K_HASH: hash_nxt[{q_item.lane, 3'b000} +: 8]     = q_item.data;
      sec_pkg::K_BODY: begin
        rhash_nxt = sec_pkg::fnv_step(rhash_r, q_item.data);
        cnt_nxt   = cnt_r + {63'd0, (cnt_r != '1)};
      end
      default: ;
    endcase
  end

  always_comb begin
    verdict = sec_pkg::V_OK;
    if (q_item.last) begin
      if (q_item.cnt < sec_pkg::VER_POS) begin
        verdict = sec_pkg::V_TRUNC;
      end else if (!magic_nxt) begin
        verdict = sec_pkg::V_MAGIC;
      end else if (q_item.cnt < sec_pkg::HDR_BYTES) begin
        verdict = sec_pkg::V_TRUNC;
      end else if (ver_nxt != exp_ver_r) begin
        verdict = sec_pkg::V_VERSION;
      end else if (len_nxt != cnt_nxt) begin
        verdict = sec_pkg::V_LENGTH;
      end else if (hash_nxt != rhash_nxt) begin
        verdict = sec_pkg::V_HASH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= sec_pkg::EXP_VER_RESET;
    end else if (cfg_wr_en) begin
      exp_ver_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= 1'b1;
      ver_r   <= '0;
      len_r   <= '0;
      hash_r  <= '0;
      rhash_r <= sec_pkg::FNV_BASIS;
      cnt_r   <= '0;
    end else if (pop) begin
      if (q_item.last) begin
        magic_r <= 1'b1;
        ver_r   <= '0;
        len_r   <= '0;
        hash_r  <= '0;
        rhash_r <= sec_pkg::FNV_BASIS;
        cnt_r   <= '0;
      end else begin
        magic_r <= magic_nxt;
        ver_r   <= ver_nxt;
        len_r   <= len_nxt;
        hash_r  <= hash_nxt;
        rhash_r <= rhash_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r    <= q_item.data;
      out_body_r    <= (q_item.kind == sec_pkg::K_BODY);
      out_last_r    <= q_item.last;
      out_verdict_r <= verdict;
    end
  end

  `SEC_ASSERT(a_verdict_only_last,
              out_valid_r && !out_last_r |-> out_verdict_r == sec_pkg::V_OK,
              "verdict set on a beat that does not end the frame")
  `SEC_ASSERT(a_clear_after_last,
              pop && q_item.last |=> cnt_r == '0 && rhash_r == sec_pkg::FNV_BASIS && magic_r,
              "frame state not cleared after the last beat")

endmodule
`default_nettype wire

// File: sv/snapshot_envelope_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snapshot_envelope_checker
// Framed snapshot byte-stream checker with an FNV-1a 64 body hash.
// ----------------------------------------------------------------------------
// Each input beat carries one byte; tlast marks the final byte of a snapshot.
// A snapshot opens with a 28-byte header: the magic "OFSTATE1", a 32-bit
// little-endian version, a 64-bit little-endian body length and the 64-bit
// little-endian FNV-1a hash of the body. Every input beat yields exactly one
// output beat carrying the same byte; out_tuser is high for body bytes. On the
// final byte out_tlast is high and the verdict field holds 0 ok, 1 truncated,
// 2 bad magic, 3 bad version, 4 length mismatch or 5 hash mismatch, judged in
// that file order (truncated before the magic is complete, then magic, then
// truncated header, then version, length and hash); otherwise it is 0. The
// body count saturates at 2^64-1. The block takes one beat per clock while the
// output is not stalled: a front stage accepts and classifies, a register queue of
// QUEUE_DEPTH entries decouples it from the back stage, which does the
// shift-add FNV multiply, field capture and verdict combinationally and loads
// the output register. A result passes through the queue and the output
// register before it is offered on the output. Write expected_version (reset 4)
// only while no frame is in flight.
// ----------------------------------------------------------------------------
module snapshot_envelope_checker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // last_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [7:0] body_byte, [10:8] verdict, rest zero
  output logic             out_tuser,   // body_valid
  output logic             out_tlast,   // frame_done
  // Configuration: expected_version
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  sec_pkg::item_t push_item, pop_item;
  logic           push, pop, q_full, q_not_empty;
  logic [7:0]     out_byte;
  logic [2:0]     out_verdict;

  // Front: accept beats while the queue has room, tag each with its role
  sec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: hold classified beats so either side can stall alone
  sec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_not_empty)
  );

  // Back: advance hash and fields, judge on the last beat, drive the output
  sec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_byte),
    .out_body    (out_tuser),
    .out_last    (out_tlast),
    .out_verdict (out_verdict)
  );

  // Pack the result beat, pad to whole bytes
  assign out_tdata = {5'd0, out_verdict, out_byte};

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot envelope checker testbench
// Builds snapshot frames (header plus body), both well formed and damaged in
// one field at a time, and streams them byte by byte with random gaps on the
// input and random stalls on the output. A model of the header
// parser, FNV-1a 64 body hash and verdict order predicts every output beat,
// and each accepted output beat is compared field by field against it.
// ----------------------------------------------------------------------------
module tb;

  // Header layout and hash constants, kept independent of the RTL
  localparam int          VERSION_AT    = 8;
  localparam int          LENGTH_AT     = 12;
  localparam int          HASH_AT       = 20;
  localparam int          HEADER_LEN    = 28;
  localparam logic [63:0] SNAP_MAGIC    = "1ETATSFO";  // 'O' sits in the low byte
  localparam logic [63:0] FNV_OFFSET    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_PRIME     = 64'd1099511628211;
  localparam logic [31:0] RESET_VERSION = 32'd4;

  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_BEATS   = 280;
  localparam int HOLD_STRETCH  = 150;

  // Ways a generated snapshot can be damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_LENGTH,
    FLAW_HASH,
    FLAW_CUT,
    FLAW_FLIP
  } flaw_t;

  typedef logic [7:0] byte_q_t[$];

  // One predicted output beat
  typedef struct packed {
    logic [7:0]        body_byte;
    logic              body_valid;
    logic              frame_done;
    sec_pkg::verdict_t verdict;
  } snap_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [7:0] body_byte, [10:8] verdict, [15:11] zero
  logic        out_tuser;   // body_valid
  logic        out_tlast;   // frame_done
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  snapshot_envelope_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Envelope state as the block should hold it
  logic [31:0] want_version;
  logic [4:0]  hdr_seen;
  logic        magic_ok;
  logic [31:0] ver_field;
  logic [63:0] len_field;
  logic [63:0] hash_field;
  logic [63:0] body_hash;
  logic [63:0] body_len;

  // Output beats still owed by the block, oldest first
  snap_result_t awaited_beats[$];
  snap_result_t head_beat;

  bit quiet       = 1'b0;  // suppress random idling on both sides
  int hold_cycles = 0;     // receiver hold-off still to run
  int cycle_count = 0;
  int beats_sent  = 0;
  int beats_seen  = 0;
  int frames_seen = 0;
  int mismatch_count   = 0;
  int versions_written = 0;
  int verdict_tally[6];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
               awaited_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  function automatic void clear_frame();
    hdr_seen   = '0;
    magic_ok   = 1'b1;
    ver_field  = '0;
    len_field  = '0;
    hash_field = '0;
    body_hash  = FNV_OFFSET;
    body_len   = '0;
  endfunction

  // Advance the envelope state by one accepted byte and return its output beat
  function automatic snap_result_t track_envelope(input logic [7:0] b, input logic last);
    snap_result_t r;
    int pos;
    pos          = int'(hdr_seen);
    r.body_byte  = b;
    r.body_valid = (pos >= HEADER_LEN);
    r.frame_done = last;
    r.verdict    = sec_pkg::V_OK;
    if (!r.body_valid) begin
      // Header bytes land little-endian into their field
      if (pos < VERSION_AT) begin
        if (b != SNAP_MAGIC[8*pos +: 8]) magic_ok = 1'b0;
      end else if (pos < LENGTH_AT) begin
        ver_field[8*(pos-VERSION_AT) +: 8] = b;
      end else if (pos < HASH_AT) begin
        len_field[8*(pos-LENGTH_AT) +: 8] = b;
      end else begin
        hash_field[8*(pos-HASH_AT) +: 8] = b;
      end
      hdr_seen = hdr_seen + 5'd1;
    end else begin
      body_hash = fnv_fold(body_hash, b);
      if (body_len != '1) body_len = body_len + 64'd1;  // count sticks at all ones
    end
    if (last) begin
      // Verdict order: short magic, magic, short header, version, length, hash
      if (hdr_seen < VERSION_AT)          r.verdict = sec_pkg::V_TRUNC;
      else if (!magic_ok)                 r.verdict = sec_pkg::V_MAGIC;
      else if (hdr_seen < HEADER_LEN)     r.verdict = sec_pkg::V_TRUNC;
      else if (ver_field != want_version) r.verdict = sec_pkg::V_VERSION;
      else if (len_field != body_len)     r.verdict = sec_pkg::V_LENGTH;
      else if (hash_field != body_hash)   r.verdict = sec_pkg::V_HASH;
      clear_frame();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Snapshot construction
  // ---------------------------------------------------------------------------
  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q = {q, 8'($urandom_range(0, 255))};
    return q;
  endfunction

  // Wrap a body in a header built for the current expected version, then
  // apply the requested damage
  function automatic byte_q_t wrap_body(input byte_q_t body, input flaw_t flaw);
    byte_q_t     q;
    logic [63:0] sig;
    logic [31:0] ver;
    logic [63:0] len;
    logic [63:0] h;
    int          k;
    sig = SNAP_MAGIC;
    ver = want_version;
    len = 64'(body.size());
    h   = FNV_OFFSET;
    foreach (body[i]) h = fnv_fold(h, body[i]);
    case (flaw)
      FLAW_MAGIC: begin
        k = $urandom_range(0, 7);
        sig[8*k +: 8] = sig[8*k +: 8] ^ 8'($urandom_range(1, 255));
      end
      FLAW_VERSION: ver = ver ^ (32'd1 << $urandom_range(0, 31));
      FLAW_LENGTH:  len = len ^ (64'd1 << $urandom_range(0, 63));
      FLAW_HASH:    h   = h ^ (64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    for (k = 0; k < 8; k++) q = {q, sig[8*k +: 8]};
    for (k = 0; k < 4; k++) q = {q, ver[8*k +: 8]};
    for (k = 0; k < 8; k++) q = {q, len[8*k +: 8]};
    for (k = 0; k < 8; k++) q = {q, h[8*k +: 8]};
    q = {q, body};
    if (flaw == FLAW_CUT) begin
      q = q[0:$urandom_range(0, q.size() - 2)];
    end else if (flaw == FLAW_FLIP) begin
      k = $urandom_range(0, q.size() - 1);
      q[k] = q[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one beat, idling at random first; record its output on acceptance
  task automatic send_beat(input logic [7:0] b, input logic last);
    snap_result_t r;
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    r = track_envelope(b, last);
    awaited_beats = {awaited_beats, r};
    beats_sent++;
  endtask

  task automatic send_stream(input byte_q_t q);
    foreach (q[i]) send_beat(q[i], i == q.size() - 1);
  endtask

  // Drop valid and wait until every owed beat has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change expected_version only with no frame in flight
  task automatic write_version(input logic [31:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    want_version  = v;
    versions_written++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  // Stall at random, or hold off for a counted stretch when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles  = hold_cycles - 1;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatch_count++;
    $display("[%0t] beat %0d: %s got 0x%0h, want 0x%0h", $time, beats_seen, what,
             seen, wanted);
  endtask

  // Compare every accepted output beat against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("unexpected beat, tdata", 64'(out_tdata), '0);
      end else begin
        head_beat = awaited_beats.pop_front();
        if (out_tdata[7:0] !== head_beat.body_byte)
          report_mismatch("body_byte", 64'(out_tdata[7:0]), 64'(head_beat.body_byte));
        if (out_tdata[10:8] !== head_beat.verdict)
          report_mismatch("verdict", 64'(out_tdata[10:8]), 64'(head_beat.verdict));
        if (out_tdata[15:11] !== 5'd0)
          report_mismatch("tdata padding", 64'(out_tdata[15:11]), '0);
        if (out_tuser !== head_beat.body_valid)
          report_mismatch("body_valid", 64'(out_tuser), 64'(head_beat.body_valid));
        if (out_tlast !== head_beat.frame_done)
          report_mismatch("frame_done", 64'(out_tlast), 64'(head_beat.frame_done));
        if (head_beat.frame_done) begin
          frames_seen++;
          verdict_tally[int'(head_beat.verdict)]++;
        end
      end
      beats_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Frames that end inside the header, with and without a good magic, and a full frame with a bad magic
  task automatic test_truncation_and_magic();
    byte_q_t full;
    byte_q_t q;
    full = wrap_body(random_body(4), FLAW_NONE);
    send_stream(full[0:0]);     // single byte frame
    send_stream(full[0:6]);     // ends inside the magic
    q = full[0:2];
    q[1] = q[1] ^ 8'h20;
    send_stream(q);             // bad magic, but too short to judge it
    q = full[0:7];
    q[7] = 8'h30;
    send_stream(q);             // last magic byte wrong
    send_stream(full[0:7]);     // magic only
    send_stream(full[0:26]);    // header one byte short
    q = full;
    q[0] = 8'h00;
    send_stream(q);             // bad magic outranks the rest
    q = full[0:26];
    q[3] = 8'hFF;
    send_stream(q);             // bad magic outranks a short header
    drain_results();
  endtask

  // Full headers: ok, version, length and hash verdicts, their priority, extreme bytes and lengths
  task automatic test_header_verdicts();
    byte_q_t none;
    byte_q_t body;
    byte_q_t q;
    int      k;
    send_stream(wrap_body(none, FLAW_NONE));  // empty body
    body = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    send_stream(wrap_body(body, FLAW_NONE));
    send_stream(wrap_body(body, FLAW_VERSION));
    send_stream(wrap_body(body, FLAW_LENGTH));
    send_stream(wrap_body(body, FLAW_HASH));
    q = wrap_body(body, FLAW_NONE);
    for (k = LENGTH_AT; k < HASH_AT; k++) q[k] = 8'hFF;
    send_stream(q);             // all-ones length
    q = wrap_body(body, FLAW_HASH);
    q[VERSION_AT] = q[VERSION_AT] ^ 8'h01;
    send_stream(q);             // version outranks hash
    q = wrap_body(body, FLAW_HASH);
    q[LENGTH_AT] = q[LENGTH_AT] ^ 8'h01;
    send_stream(q);             // length outranks hash
    drain_results();
  endtask

  // Walk expected_version through its extremes and a random value
  task automatic test_version_register();
    byte_q_t q;
    write_version(32'd0);
    send_stream(wrap_body(random_body(3), FLAW_NONE));
    q = wrap_body(random_body(2), FLAW_NONE);
    q[VERSION_AT] = 8'd4;
    send_stream(q);             // the reset version is now wrong
    write_version(32'hFFFF_FFFF);
    send_stream(wrap_body(random_body(6), FLAW_NONE));
    send_stream(wrap_body(random_body(1), FLAW_VERSION));
    write_version($urandom());
    send_stream(wrap_body(random_body(8), FLAW_NONE));
    write_version(RESET_VERSION);
    drain_results();
  endtask

  // Hold the output off long enough for the block to stop taking input
  task automatic test_output_stall();
    int k;
    hold_cycles = HOLD_STRETCH;
    for (k = 0; k < 4; k++) send_stream(wrap_body(random_body(12), FLAW_NONE));
    drain_results();
  endtask

  task automatic send_random_snapshot();
    int    pick;
    int    n;
    flaw_t flaw;
    pick = $urandom_range(0, 99);
    n    = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 16) : $urandom_range(17, 120);
    if (pick >= 92) begin
      // Unframed noise: mostly bad magic or short
      send_stream(random_body($urandom_range(1, 40)));
    end else begin
      if (pick < 45)      flaw = FLAW_NONE;
      else if (pick < 52) flaw = FLAW_MAGIC;
      else if (pick < 59) flaw = FLAW_VERSION;
      else if (pick < 66) flaw = FLAW_LENGTH;
      else if (pick < 73) flaw = FLAW_HASH;
      else if (pick < 83) flaw = FLAW_CUT;
      else                flaw = FLAW_FLIP;
      send_stream(wrap_body(random_body(n), flaw));
    end
  endtask

  // Well-formed and damaged snapshots with random content, a new version per phase
  task automatic test_random_snapshots();
    int phase;
    int stop_at;
    for (phase = 0; phase < 4; phase++) begin
      quiet   = (phase == 2);   // one phase runs back to back on both sides
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) send_random_snapshot();
      drain_results();
      quiet = 1'b0;
      write_version((phase == 1) ? 32'hFFFF_FFFF : $urandom());
    end
    write_version(RESET_VERSION);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    want_version = RESET_VERSION;
    clear_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_truncation_and_magic();
    test_header_verdicts();
    test_version_register();
    test_output_stall();
    test_random_snapshots();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d beats in %0d snapshots across %0d version writes", beats_seen,
             frames_seen, versions_written);
    $display("Verdicts: ok %0d, truncated %0d, magic %0d, version %0d, length %0d, hash %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4], verdict_tally[5]);
    if (mismatch_count == 0 && awaited_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
